// ===== rtl/frame_deadline_window_scheduler_assert.svh =====
// Assertion macros shared by the scheduler modules.
`ifndef FRAME_DEADLINE_WINDOW_SCHEDULER_ASSERT_SVH
`define FRAME_DEADLINE_WINDOW_SCHEDULER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FDWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FDWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fdws_pkg.sv =====
// -----------------------------------------------------------------------------
// fdws_pkg
// Types and constants shared by the frame deadline window scheduler.
// -----------------------------------------------------------------------------
package fdws_pkg;

    localparam int unsigned TimeW = 48;
    localparam int unsigned IdW   = 32;
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
    localparam int unsigned MsPerS = 1000;

    localparam logic [2:0] CmdUpsert  = 3'd0;
    localparam logic [2:0] CmdRemove  = 3'd1;
    localparam logic [2:0] CmdReady   = 3'd2;
    localparam logic [2:0] CmdConsume = 3'd3;
    localparam logic [2:0] CmdRetry   = 3'd4;
    localparam logic [2:0] CmdNext    = 3'd5;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StIgnored = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;
    localparam logic [1:0] StNone    = 2'd3;

    localparam logic [1:0] RoleHidden = 2'd0;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [IdW-1:0]   window_id;
        logic [TimeW-1:0] now_ms;
        logic [7:0]       target_fps;
        logic [1:0]       role;
        logic [IdW-1:0]   generation;
        logic [7:0]       priority_req;
        logic             frame_ready;
        logic [15:0]      retry_delay_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [IdW-1:0]   sel_window_id;
        logic [IdW-1:0]   sel_generation;
        logic [TimeW-1:0] sel_deadline_ms;
        logic [7:0]       sel_priority;
        logic             sel_overdue;
        logic [4:0]       entry_count;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word, clear the scan results
        logic scan;     // examine the slot at the scan index
        logic apply;    // carry out the command using the scan results
        logic finish;   // build the result word
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

    // Builds the frame interval for every rate at elaboration, ten bits per
    // rate, with a restoring long division of 1000 by the rate. Rate zero
    // holds 1 and is never looked up for a due time.
    function automatic logic [256*10-1:0] build_interval_rom();
        logic [256*10-1:0] rom;
        int unsigned q;
        int unsigned rem;
        rom = '0;
        rom[9:0] = 10'd1;
        for (int unsigned f = 1; f < 256; f++) begin
            q = 0;
            rem = MsPerS;
            for (int b = 9; b >= 0; b--) begin
                if (rem >= (f << b)) begin
                    rem = rem - (f << b);
                    q = q | (32'd1 << b);
                end
            end
            if (q == 0) begin
                q = 1;
            end
            rom[f*10 +: 10] = 10'(q);
        end
        return rom;
    endfunction

    localparam logic [256*10-1:0] FrameIvRom = build_interval_rom();

    // Frame interval 1000 / fps, at least 1, for fps 1 to 255.
    function automatic logic [9:0] frame_interval(input logic [7:0] fps);
        return FrameIvRom[10*int'(fps) +: 10];
    endfunction

    function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                 input logic [15:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {{(TimeW-15){1'b0}}, b};
        return s[TimeW] ? TimeMax : s[TimeW-1:0];
    endfunction

endpackage

// ===== rtl/fdws_ctrl.sv =====
// -----------------------------------------------------------------------------
// fdws_ctrl
// Sequencer: accept a word, scan all slots, apply, then present the result.
// -----------------------------------------------------------------------------
module fdws_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  fdws_pkg::t_dp_sts  i_sts,
    output fdws_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_APPLY  = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `include "frame_deadline_window_scheduler_assert.svh"

    `FDWS_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state), "state not one-hot")
    `FDWS_ASSERT_NEXT(a_load_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN, "load not followed by scan")
    `FDWS_ASSERT_NEXT(a_apply_fin, i_clk, i_rst_n, o_cmd.apply, o_cmd.finish, "apply not followed by finish")

endmodule

// ===== rtl/fdws_dp.sv =====
// -----------------------------------------------------------------------------
// fdws_dp
// Slot table, one-slot-per-cycle scan with running best pick, and updates.
// -----------------------------------------------------------------------------
module fdws_dp #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdws_pkg::t_in_word   i_in,
    input  fdws_pkg::t_dp_cmd    i_cmd,
    output fdws_pkg::t_dp_sts    o_sts,
    output fdws_pkg::t_out_word  o_out
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned TW = fdws_pkg::TimeW;

    logic [ENTRIES-1:0]    r_valid;
    logic [31:0]           r_win  [ENTRIES];
    logic [7:0]            r_fps  [ENTRIES];
    logic [1:0]            r_role [ENTRIES];
    logic [31:0]           r_gen  [ENTRIES];
    logic [7:0]            r_prio [ENTRIES];
    logic [ENTRIES-1:0]    r_ready;
    logic [TW-1:0]         r_due  [ENTRIES];
    logic [31:0]           r_cursor;
    logic [CW-1:0]         r_count;

    fdws_pkg::t_in_word    r_in;
    logic [IW-1:0]         r_idx;
    logic                  r_hit, r_free_ok, r_pick_ok;
    logic [IW-1:0]         r_hit_idx, r_free_idx, r_pick;
    logic [1:0]            r_status;
    fdws_pkg::t_out_word   r_out;
    fdws_pkg::t_out_word   n_out;

    assign o_sts.scan_last = (r_idx == IW'(ENTRIES - 1));
    assign o_out = r_out;

    // Comparison of the scanned slot against the current best.
    logic cand, better, da, db, ca, cb;
    always_comb begin
        cand = r_valid[r_idx] && r_ready[r_idx] && (r_role[r_idx] != fdws_pkg::RoleHidden);
        da = r_due[r_idx] <= r_in.now_ms;
        db = r_due[r_pick] <= r_in.now_ms;
        ca = r_win[r_idx] > r_cursor;
        cb = r_win[r_pick] > r_cursor;
        if (da != db)                           better = da;
        else if (r_role[r_idx] != r_role[r_pick]) better = r_role[r_idx] > r_role[r_pick];
        else if (r_due[r_idx] != r_due[r_pick])   better = r_due[r_idx] < r_due[r_pick];
        else if (ca != cb)                      better = ca;
        else if (r_prio[r_idx] != r_prio[r_pick]) better = r_prio[r_idx] > r_prio[r_pick];
        else                                    better = r_win[r_idx] < r_win[r_pick];
    end

    logic [TW-1:0] consume_due;
    always_comb begin
        if (r_fps[r_hit_idx] == 8'd0) begin
            consume_due = fdws_pkg::TimeMax;
        end else begin
            consume_due = fdws_pkg::sat_add(r_in.now_ms,
                {6'd0, fdws_pkg::frame_interval(r_fps[r_hit_idx])});
        end
    end

    logic [15:0] retry_d;
    assign retry_d = (r_in.retry_delay_ms == 16'd0) ? 16'd1 : r_in.retry_delay_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cursor <= '0;
            r_count  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_in      <= i_in;
                r_idx     <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_pick_ok <= 1'b0;
                r_pick    <= '0;
            end
            if (i_cmd.scan) begin
                if (!o_sts.scan_last) r_idx <= r_idx + 1'b1;
                if (r_valid[r_idx] && r_win[r_idx] == r_in.window_id && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                end
                if (!r_valid[r_idx] && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_idx;
                end
                if (cand && (!r_pick_ok || better)) begin
                    r_pick_ok <= 1'b1;
                    r_pick    <= r_idx;
                end
            end
            if (i_cmd.apply) begin
                case (r_in.cmd)
                    fdws_pkg::CmdUpsert: begin
                        if (r_in.window_id != 32'd0) begin
                            if (r_hit) begin
                                if (r_fps[r_hit_idx] != r_in.target_fps ||
                                    r_role[r_hit_idx] != r_in.role ||
                                    r_gen[r_hit_idx] != r_in.generation) begin
                                    if (r_in.now_ms < r_due[r_hit_idx])
                                        r_due[r_hit_idx] <= r_in.now_ms;
                                end
                                r_fps[r_hit_idx]   <= r_in.target_fps;
                                r_role[r_hit_idx]  <= r_in.role;
                                r_gen[r_hit_idx]   <= r_in.generation;
                                r_prio[r_hit_idx]  <= r_in.priority_req;
                                r_ready[r_hit_idx] <= r_in.frame_ready;
                                r_status <= fdws_pkg::StOk;
                            end else if (r_free_ok) begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_win[r_free_idx]   <= r_in.window_id;
                                r_due[r_free_idx]   <= r_in.now_ms;
                                r_fps[r_free_idx]   <= r_in.target_fps;
                                r_role[r_free_idx]  <= r_in.role;
                                r_gen[r_free_idx]   <= r_in.generation;
                                r_prio[r_free_idx]  <= r_in.priority_req;
                                r_ready[r_free_idx] <= r_in.frame_ready;
                                r_count  <= r_count + 1'b1;
                                r_status <= fdws_pkg::StOk;
                            end else begin
                                r_status <= fdws_pkg::StFull;
                            end
                        end else begin
                            r_status <= fdws_pkg::StIgnored;
                        end
                    end
                    fdws_pkg::CmdRemove: begin
                        if (r_hit) begin
                            r_valid[r_hit_idx] <= 1'b0;
                            r_count  <= r_count - 1'b1;
                            r_status <= fdws_pkg::StOk;
                        end else begin
                            r_status <= fdws_pkg::StIgnored;
                        end
                    end
                    fdws_pkg::CmdReady: begin
                        if (r_hit && r_gen[r_hit_idx] == r_in.generation) begin
                            r_ready[r_hit_idx] <= 1'b1;
                            r_status <= fdws_pkg::StOk;
                        end else begin
                            r_status <= fdws_pkg::StIgnored;
                        end
                    end
                    fdws_pkg::CmdConsume: begin
                        if (r_hit) begin
                            r_ready[r_hit_idx] <= 1'b0;
                            r_due[r_hit_idx]   <= consume_due;
                            r_cursor <= r_in.window_id;
                            r_status <= fdws_pkg::StOk;
                        end else begin
                            r_status <= fdws_pkg::StIgnored;
                        end
                    end
                    fdws_pkg::CmdRetry: begin
                        if (r_hit) begin
                            r_ready[r_hit_idx] <= 1'b1;
                            r_due[r_hit_idx]   <= fdws_pkg::sat_add(r_in.now_ms, retry_d);
                            r_cursor <= r_in.window_id;
                            r_status <= fdws_pkg::StOk;
                        end else begin
                            r_status <= fdws_pkg::StIgnored;
                        end
                    end
                    fdws_pkg::CmdNext: begin
                        if (r_pick_ok && r_due[r_pick] <= r_in.now_ms)
                            r_status <= fdws_pkg::StOk;
                        else
                            r_status <= fdws_pkg::StNone;
                    end
                    default: r_status <= fdws_pkg::StIgnored;
                endcase
            end
        end
    end

    // Result word; the next command's fields are taken from the pick.
    always_comb begin
        n_out = '0;
        n_out.status      = r_status;
        n_out.entry_count = 5'(r_count);
        if (r_in.cmd == fdws_pkg::CmdNext && r_status == fdws_pkg::StOk) begin
            n_out.sel_window_id   = r_win[r_pick];
            n_out.sel_generation  = r_gen[r_pick];
            n_out.sel_deadline_ms = r_due[r_pick];
            n_out.sel_priority    = r_prio[r_pick];
            n_out.sel_overdue     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    `include "frame_deadline_window_scheduler_assert.svh"

    `FDWS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES), "count overflow")
    `FDWS_ASSERT_IMP(a_count_pop, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_valid)), "count mismatch")
    `FDWS_ASSERT_NEXT(a_load_idx, i_clk, i_rst_n, i_cmd.load, r_idx == '0, "scan index not cleared")

endmodule

// ===== rtl/frame_deadline_window_scheduler.sv =====
// The block takes a new word only once the result word of the last one has been
// taken; the slot scan visits one table slot per cycle.
// Reset (synchronous, active low) clears all slot valid flags, the round-robin
// cursor and the entry count; no clearing pass is needed.
// -----------------------------------------------------------------------------
// frame_deadline_window_scheduler
// Top level: per-window frame deadline table with round-robin selection.
// -----------------------------------------------------------------------------
module frame_deadline_window_scheduler #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fdws_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fdws_pkg::t_out_word  o_out_data
);

    // The controller sequences load, scan, apply and finish; the datapath
    // holds the table and produces the result word, which stays stable while
    // the output is stalled.
    fdws_pkg::t_dp_cmd cmd;
    fdws_pkg::t_dp_sts sts;

    fdws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fdws_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out_data)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_deadline_window_scheduler: a queue-fed driver
// offers command words, a monitor predicts each result from a software copy of
// the window table and compares every result word field by field.
// -----------------------------------------------------------------------------
module testbench;

    typedef fdws_pkg::t_in_word  t_in_word;
    typedef fdws_pkg::t_out_word t_out_word;

    localparam int unsigned TimeW = fdws_pkg::TimeW;
    localparam int unsigned IdW   = fdws_pkg::IdW;
    localparam logic [TimeW-1:0] TimeMax = fdws_pkg::TimeMax;

    // Command codes the block does not define; they must be ignored.
    localparam logic [2:0] CmdSpareLo = 3'd6;
    localparam logic [2:0] CmdSpareHi = 3'd7;

    localparam int unsigned Slots = 16;
    localparam int unsigned RandItems = 630;
    localparam int unsigned KeyPool = 23;
    localparam int unsigned HoldCycles = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b1;
    t_out_word out_word;

    // Command words waiting to be offered, and results the table should produce.
    t_in_word  cmd_backlog[$];
    t_out_word result_queue[$];

    // Software copy of the window table.
    logic             win_valid[Slots];
    logic [IdW-1:0]   win_key[Slots];
    logic [7:0]       win_fps[Slots];
    logic [1:0]       win_role[Slots];
    logic [IdW-1:0]   win_gen[Slots];
    logic [7:0]       win_prio[Slots];
    logic             win_ready[Slots];
    logic [TimeW-1:0] win_due[Slots];
    logic [IdW-1:0]   last_served;

    int  words_taken = 0;
    int  error_count = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    logic in_taken = 1'b0;

    frame_deadline_window_scheduler #(.ENTRIES(Slots)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // The run goes through idling phases by how many words have been accepted:
    // none, sender idle, receiver stalling, both lightly, none again.
    function automatic int idle_phase();
        return words_taken / 130;
    endfunction

    // True when slot a should be served ahead of slot b at time now.
    function automatic bit outranks(int a, int b, logic [TimeW-1:0] now);
        bit due_a, due_b, after_a, after_b;
        due_a = win_due[a] <= now;
        due_b = win_due[b] <= now;
        if (due_a != due_b) return due_a;
        if (win_role[a] != win_role[b]) return win_role[a] > win_role[b];
        if (win_due[a] != win_due[b]) return win_due[a] < win_due[b];
        after_a = win_key[a] > last_served;
        after_b = win_key[b] > last_served;
        if (after_a != after_b) return after_a;
        if (win_prio[a] != win_prio[b]) return win_prio[a] > win_prio[b];
        return win_key[a] < win_key[b];
    endfunction

    function automatic logic [TimeW-1:0] add_capped(logic [TimeW-1:0] a, int unsigned b);
        logic [TimeW:0] s;
        s = {1'b0, a} + (TimeW+1)'(b);
        return s[TimeW] ? TimeMax : s[TimeW-1:0];
    endfunction

    // Applies one command word to the table copy and returns the result word.
    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word r;
        int slot, pick, n;
        int unsigned iv;
        r = '0;
        r.status = fdws_pkg::StIgnored;
        slot = -1;
        pick = -1;
        for (int i = 0; i < Slots; i++)
            if (slot < 0 && win_valid[i] && win_key[i] == w.window_id) slot = i;
        case (w.cmd)
            fdws_pkg::CmdUpsert: begin
                if (w.window_id != '0) begin
                    if (slot < 0) begin
                        for (int i = 0; i < Slots; i++)
                            if (slot < 0 && !win_valid[i]) slot = i;
                        if (slot >= 0) begin
                            win_valid[slot] = 1'b1;
                            win_key[slot] = w.window_id;
                            win_due[slot] = w.now_ms;
                        end
                    end else if (win_fps[slot] != w.target_fps || win_role[slot] != w.role
                                 || win_gen[slot] != w.generation) begin
                        if (w.now_ms < win_due[slot]) win_due[slot] = w.now_ms;
                    end
                    if (slot < 0) begin
                        r.status = fdws_pkg::StFull;
                    end else begin
                        win_fps[slot] = w.target_fps;
                        win_role[slot] = w.role;
                        win_gen[slot] = w.generation;
                        win_prio[slot] = w.priority_req;
                        win_ready[slot] = w.frame_ready;
                        r.status = fdws_pkg::StOk;
                    end
                end
            end
            fdws_pkg::CmdRemove: begin
                if (slot >= 0) begin
                    win_valid[slot] = 1'b0;
                    r.status = fdws_pkg::StOk;
                end
            end
            fdws_pkg::CmdReady: begin
                if (slot >= 0 && win_gen[slot] == w.generation) begin
                    win_ready[slot] = 1'b1;
                    r.status = fdws_pkg::StOk;
                end
            end
            fdws_pkg::CmdConsume: begin
                if (slot >= 0) begin
                    win_ready[slot] = 1'b0;
                    if (win_fps[slot] == 8'd0) begin
                        win_due[slot] = TimeMax;
                    end else begin
                        iv = fdws_pkg::MsPerS / int'(win_fps[slot]);
                        win_due[slot] = add_capped(w.now_ms, (iv < 1) ? 1 : iv);
                    end
                    last_served = w.window_id;
                    r.status = fdws_pkg::StOk;
                end
            end
            fdws_pkg::CmdRetry: begin
                if (slot >= 0) begin
                    win_ready[slot] = 1'b1;
                    win_due[slot] = add_capped(w.now_ms,
                        (w.retry_delay_ms == 16'd0) ? 1 : int'(w.retry_delay_ms));
                    last_served = w.window_id;
                    r.status = fdws_pkg::StOk;
                end
            end
            fdws_pkg::CmdNext: begin
                for (int i = 0; i < Slots; i++) begin
                    if (win_valid[i] && win_ready[i] && win_role[i] != fdws_pkg::RoleHidden)
                        if (pick < 0 || outranks(i, pick, w.now_ms)) pick = i;
                end
                if (pick < 0 || win_due[pick] > w.now_ms) begin
                    r.status = fdws_pkg::StNone;
                end else begin
                    r.status = fdws_pkg::StOk;
                    r.sel_window_id = win_key[pick];
                    r.sel_generation = win_gen[pick];
                    r.sel_deadline_ms = win_due[pick];
                    r.sel_priority = win_prio[pick];
                    r.sel_overdue = 1'b1;
                end
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < Slots; i++) n += win_valid[i];
        r.entry_count = 5'(n);
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Appends a command word to the end of the backlog.
    function automatic void queue_cmd(t_in_word w);
        cmd_backlog.insert(cmd_backlog.size(), w);
    endfunction

    // Monitor: handshakes are sampled at the rising edge. Accepted command
    // words are run through the table copy right away, so expected results
    // line up in the order the block must return them.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                result_queue.insert(result_queue.size(), schedule_step(in_word));
                words_taken++;
            end
            if (out_valid && !out_stall) begin
                if (result_queue.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    want = result_queue.pop_front();
                    compare_field("status", want.status, out_word.status);
                    compare_field("sel_window_id", want.sel_window_id, out_word.sel_window_id);
                    compare_field("sel_generation", want.sel_generation,
                                  out_word.sel_generation);
                    compare_field("sel_deadline_ms", want.sel_deadline_ms,
                                  out_word.sel_deadline_ms);
                    compare_field("sel_priority", want.sel_priority, out_word.sel_priority);
                    compare_field("sel_overdue", want.sel_overdue, out_word.sel_overdue);
                    compare_field("entry_count", want.entry_count, out_word.entry_count);
                end
            end
        end
    end

    // Driver: a word stays on the bus until accepted; only then may the next
    // one (or an idle cycle) follow. Idling never looks at the stall.
    always @(negedge i_clk) begin
        bit idle;
        int ph;
        ph = idle_phase();
        idle = (ph == 1) ? ($urandom_range(0, 99) < 79) :
               (ph == 3) ? ($urandom_range(0, 99) < 29) : 1'b0;
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (!idle && cmd_backlog.size() != 0) begin
                in_word <= cmd_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls by phase, and once holds off for a long stretch while
    // the sender keeps offering words so the block backs up to its input.
    always @(negedge i_clk) begin
        int ph;
        ph = idle_phase();
        if (!i_rst_n) begin
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && words_taken >= 60) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            out_stall <= 1'b1;
        end else if (ph == 2) begin
            out_stall <= ($urandom_range(0, 99) < 79);
        end else if (ph == 3) begin
            out_stall <= ($urandom_range(0, 99) < 29);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic t_in_word make_word(logic [2:0] cmd, logic [IdW-1:0] key,
                                           logic [TimeW-1:0] now, logic [7:0] fps,
                                           logic [1:0] role, logic [IdW-1:0] gen,
                                           logic [7:0] prio, logic rdy, logic [15:0] delay);
        t_in_word w;
        w.cmd = cmd;
        w.window_id = key;
        w.now_ms = now;
        w.target_fps = fps;
        w.role = role;
        w.generation = gen;
        w.priority_req = prio;
        w.frame_ready = rdy;
        w.retry_delay_ms = delay;
        return w;
    endfunction

    initial begin
        logic [TimeW-1:0] clock_ms;
        logic [IdW-1:0]   key_gen[KeyPool];
        logic [IdW-1:0]   key, gen;
        logic [TimeW-1:0] now;
        logic [7:0]       fps;
        logic [2:0]       cmd;
        logic [15:0]      delay;
        int               pick;

        for (int i = 0; i < Slots; i++) win_valid[i] = 1'b0;
        last_served = '0;
        for (int i = 0; i < KeyPool; i++) key_gen[i] = '0;
        clock_ms = 48'd1000;

        // Directed part: extreme keys and fields, each command, hidden windows,
        // generation mismatch, zero frame rate, saturation and unused codes.
        queue_cmd(make_word(fdws_pkg::CmdUpsert, '0, 48'd100, 8'd30, 2'd3, '0, 8'd1,
                            1'b1, '0));
        queue_cmd(make_word(fdws_pkg::CmdUpsert, '1, 48'd100, 8'd255, 2'd3, '1, 8'd255,
                            1'b1, '1));
        queue_cmd(make_word(fdws_pkg::CmdUpsert, 32'd1, 48'd100, 8'd0, 2'd1, '0, 8'd0,
                            1'b1, '0));
        queue_cmd(make_word(fdws_pkg::CmdUpsert, 32'd2, 48'd100, 8'd30, fdws_pkg::RoleHidden,
                            32'd7, 8'd9, 1'b1, '0));
        queue_cmd(make_word(fdws_pkg::CmdNext, '0, 48'd100, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdConsume, '1, 48'd100, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdConsume, 32'd1, 48'd100, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdNext, '0, 48'd101, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdReady, 32'd1, 48'd101, '0, '0, 32'd5, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdReady, 32'd1, 48'd101, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdNext, '0, TimeMax, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdRetry, '1, 48'd200, '0, '0, '0, '0, 1'b0, 16'd0));
        queue_cmd(make_word(fdws_pkg::CmdRetry, '1, TimeMax - 48'd5, '0, '0, '0, '0,
                            1'b0, '1));
        queue_cmd(make_word(fdws_pkg::CmdUpsert, '1, 48'd300, 8'd255, 2'd3, 32'd3, 8'd255,
                            1'b1, '0));
        queue_cmd(make_word(fdws_pkg::CmdNext, '0, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdRemove, 32'd9, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdRemove, 32'd2, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(CmdSpareLo, 32'd1, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(CmdSpareHi, 32'd1, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdConsume, 32'd77, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdRetry, 32'd77, 48'd300, '0, '0, '0, '0, 1'b0, '0));
        queue_cmd(make_word(fdws_pkg::CmdNext, '0, '0, '0, '0, '0, '0, 1'b0, '0));

        // Random part: keys mostly from a pool larger than the table, so it
        // fills up; time mostly moves forward so deadlines come due.
        for (int n = 0; n < RandItems; n++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 20) ? fdws_pkg::CmdUpsert : (pick < 28) ? fdws_pkg::CmdRemove :
                  (pick < 43) ? fdws_pkg::CmdReady : (pick < 55) ? fdws_pkg::CmdConsume :
                  (pick < 65) ? fdws_pkg::CmdRetry : (pick < 96) ? fdws_pkg::CmdNext :
                  (($urandom_range(0, 1) == 0) ? CmdSpareLo : CmdSpareHi);
            pick = $urandom_range(0, KeyPool - 1);
            key = ($urandom_range(0, 24) == 0) ? $urandom : IdW'(pick);
            if ($urandom_range(0, 49) == 0) begin
                now = {16'($urandom), 32'($urandom)};
            end else begin
                clock_ms = clock_ms + 48'($urandom_range(0, 40));
                now = ($urandom_range(0, 99) == 0) ? TimeMax : clock_ms;
            end
            case ($urandom_range(0, 6))
                0: fps = 8'd0;
                1: fps = 8'd1;
                2: fps = 8'd30;
                3: fps = 8'd60;
                4: fps = 8'd255;
                default: fps = 8'($urandom);
            endcase
            gen = ($urandom_range(0, 9) == 0) ? $urandom : IdW'($urandom_range(0, 3));
            if (cmd == fdws_pkg::CmdReady && key < KeyPool && $urandom_range(0, 4) != 0)
                gen = key_gen[key];
            if (cmd == fdws_pkg::CmdUpsert && key < KeyPool) key_gen[key] = gen;
            delay = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
            queue_cmd(make_word(cmd, key, now, fps, 2'($urandom_range(0, 3)), gen,
                                8'($urandom), 1'($urandom), delay));
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (cmd_backlog.size() == 0 && !in_valid);
        wait (result_queue.size() == 0);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("frame_deadline_window_scheduler test passed");
        end else begin
            $display("frame_deadline_window_scheduler test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("frame_deadline_window_scheduler test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fdws_pkg.sv
rtl/fdws_ctrl.sv
rtl/fdws_dp.sv
rtl/frame_deadline_window_scheduler.sv
verif/testbench.sv
